@@ rtl/nbrp_pkg.sv @@
// Shared types and constants of the row-range partitioner.
package nbrp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_COUNT = 2'd1;
  localparam logic [1:0] CFG_TOTAL_NNZ   = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One quotient bit per cycle over a 33-bit dividend.
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Word passed from the row classifier to the range sequencer.
  typedef struct packed {
    logic        has_split;
    logic        is_final;
    logic [5:0]  blk;
    logic [24:0] start;
    logic [24:0] row;
    logic [24:0] rows;
    logic [6:0]  blocks;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SPLIT,
    BK_OPEN,
    BK_TAIL
  } back_state_t;

endpackage

@@ rtl/nbrp_target_div.sv @@
// Serial divider that derives the per-block nonzero target.
module nbrp_target_div
  import nbrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] numer,
  input  logic [6:0]  denom,
  output logic        busy,
  output logic [31:0] target
);

  logic [6:0]           rem;
  logic [32:0]          quo;
  logic [6:0]           dvs;
  logic [DIV_CNT_W-1:0] cnt;

  logic [7:0]  trial;
  logic        ge;
  logic [6:0]  rem_next;
  logic [32:0] quo_next;

  always_comb begin
    trial    = {rem, quo[32]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? 7'(trial - {1'b0, dvs}) : trial[6:0];
    quo_next = {quo[31:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      target <= 32'd1;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS);
      rem  <= '0;
      quo  <= numer;
      dvs  <= denom;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy   <= 1'b0;
        // A zero quotient still gives a target of one.
        target <= (quo_next == '0) ? 32'd1 : quo_next[31:0];
      end
    end
  end

  a_target_nonzero: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> target != 32'd0)
    else $error("derived target is zero");

endmodule

@@ rtl/nbrp_front.sv @@
// Row classifier: tracks the open range and decides where ranges close.
module nbrp_front
  import nbrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [23:0] row_nnz,
  input  logic [24:0] rows,
  input  logic [6:0]  blocks,
  input  logic [31:0] target,
  output logic        first_row,
  output logic        cmd_push,
  output cmd_t        cmd
);

  logic [24:0] row_counter;
  logic [6:0]  current_block;
  logic [24:0] open_range_start;
  logic [32:0] accumulated_nnz;

  logic [33:0] sum;
  logic [32:0] acc_sum;
  logic [24:0] rem_rows;
  logic [6:0]  rem_blocks;
  logic        split;
  logic        last_row;

  always_comb begin
    sum        = {1'b0, accumulated_nnz} + {10'd0, row_nnz};
    acc_sum    = sum[33] ? '1 : sum[32:0];
    rem_rows   = rows - row_counter;
    rem_blocks = blocks - current_block;
    split      = ({1'b0, current_block} + 8'd1 < {1'b0, blocks})
              && (accumulated_nnz != '0)
              && (acc_sum > {1'b0, target})
              && (rem_rows >= {18'd0, rem_blocks});
    last_row   = ({1'b0, row_counter} + 26'd1 >= {1'b0, rows});
  end

  always_comb begin
    cmd.has_split = split;
    cmd.is_final  = last_row;
    cmd.blk       = current_block[5:0];
    cmd.start     = open_range_start;
    cmd.row       = row_counter;
    cmd.rows      = rows;
    cmd.blocks    = blocks;
    cmd_push      = take && (split || last_row);
    first_row     = (row_counter == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter      <= '0;
      current_block    <= '0;
      open_range_start <= '0;
      accumulated_nnz  <= '0;
    end else if (take) begin
      if (last_row) begin
        row_counter      <= '0;
        current_block    <= '0;
        open_range_start <= '0;
        accumulated_nnz  <= '0;
      end else begin
        row_counter <= row_counter + 25'd1;
        if (split) begin
          current_block    <= current_block + 7'd1;
          open_range_start <= row_counter;
          accumulated_nnz  <= {9'd0, row_nnz};
        end else begin
          accumulated_nnz <= acc_sum;
        end
      end
    end
  end

  a_block_in_range: assert property (@(posedge clk) disable iff (rst)
    (row_counter != '0) |-> (current_block < blocks))
    else $error("open range belongs to a block past the block count");

endmodule

@@ rtl/nbrp_queue.sv @@
// Small FIFO of range commands between classifier and sequencer.
module nbrp_queue
  import nbrp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  input  logic rd,
  output cmd_t rd_data,
  output logic full,
  output logic empty
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> (!full || rd))
    else $error("command queue written while full");

endmodule

@@ rtl/nbrp_back.sv @@
// Range sequencer: expands each command into result words.
module nbrp_back
  import nbrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [5:0]  block_index,
  output logic [24:0] range_start,
  output logic [24:0] range_end,
  output logic        last
);

  back_state_t state;
  back_state_t state_next;
  cmd_t        cmd;
  logic [6:0]  blk_cnt;
  logic [24:0] cur_start;
  logic        out_valid;

  logic        adv;
  logic        tail_last;
  logic        emit;
  logic [5:0]  e_blk;
  logic [24:0] e_start;
  logic [24:0] e_end;
  logic        e_last;

  assign adv       = !out_valid || pop;
  assign tail_last = (blk_cnt + 7'd1 >= cmd.blocks);
  assign empty     = !out_valid;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = head.has_split ? BK_SPLIT : BK_OPEN;
        end
      end
      BK_SPLIT: begin
        if (adv) begin
          state_next = cmd.is_final ? BK_OPEN : BK_IDLE;
        end
      end
      BK_OPEN, BK_TAIL: begin
        if (adv) begin
          state_next = tail_last ? BK_IDLE : BK_TAIL;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Word produced in the current state.
  always_comb begin
    q_pop   = 1'b0;
    emit    = 1'b0;
    e_blk   = blk_cnt[5:0];
    e_start = cur_start;
    e_end   = cmd.rows;
    e_last  = tail_last;
    unique case (state)
      BK_IDLE: begin
        q_pop = !q_empty;
      end
      BK_SPLIT: begin
        emit   = adv;
        e_end  = cmd.row;
        e_last = !cmd.is_final;
      end
      BK_OPEN: begin
        emit = adv;
      end
      BK_TAIL: begin
        emit    = adv;
        e_start = cmd.rows;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= emit || (out_valid && !pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd       <= head;
      blk_cnt   <= {1'b0, head.blk};
      cur_start <= head.start;
    end else if (emit) begin
      blk_cnt <= blk_cnt + 7'd1;
      if (state == BK_SPLIT) begin
        cur_start <= cmd.row;
      end
    end
    if (emit) begin
      block_index <= e_blk;
      range_start <= e_start;
      range_end   <= e_end;
      last        <= e_last;
    end
  end

  a_tail_block_valid: assert property (@(posedge clk) disable iff (rst)
    (state == BK_OPEN || state == BK_TAIL) |-> (blk_cnt < cmd.blocks))
    else $error("range issued to a block past the block count");

endmodule

@@ rtl/nnz_balanced_row_partitioner.sv @@
// Top level of the nonzero-balanced row partitioner.
//
// Rows of a sparse matrix arrive in order as words on the input queue port
// (push/full); each word carries the row's nonzero count. Range words leave
// on the output queue port (empty/pop), oldest first: block index, first
// row, row after the last, and a last flag on the final word a row caused.
// Configuration (row_count, block_count, total_nnz) is written through the
// cfg_write/cfg_index/cfg_data port before a matrix starts; writes during a
// matrix are dropped. Each accepted write starts a serial divider for the
// per-block target that holds full high while it runs. Rows that close no
// range are taken one per cycle while full is low. A row that closes a
// range goes through the command queue to the sequencer, which registers
// its word on the output. The final row expands into one word per remaining
// block, one per cycle while the receiver pops; the sequencer passes its idle
// state per command from the 4-entry command queue; full rises when it fills.
// A stalled receiver holds the output register; the classifier keeps going
// until the queue fills. Reset clears all range state and sets the target
// to one, with row_count and block_count one and total_nnz zero.
module nnz_balanced_row_partitioner
  import nbrp_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [23:0] row_nnz,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  block_index,
  output logic [24:0] range_start,
  output logic [24:0] range_end,
  output logic        last,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [24:0] row_count;
  logic [6:0]  block_count;
  logic [31:0] total_nnz;
  logic [24:0] row_count_next;
  logic [6:0]  block_count_next;
  logic [31:0] total_nnz_next;

  logic        first_row;
  logic        cfg_known;
  logic        cfg_take;
  logic [24:0] rows_eff;
  logic [6:0]  blocks_eff;
  logic [6:0]  blocks_eff_next;
  logic [32:0] div_numer;
  logic        div_busy;
  logic [31:0] target;

  logic        take;
  logic        cmd_push;
  cmd_t        cmd_in;
  cmd_t        cmd_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  function automatic logic [6:0] clamp_blocks(input logic [6:0] b);
    if (b == '0) begin
      return 7'd1;
    end else if (b > 7'(MAX_BLOCKS)) begin
      return 7'(MAX_BLOCKS);
    end
    return b;
  endfunction

  always_comb begin
    row_count_next   = row_count;
    block_count_next = block_count;
    total_nnz_next   = total_nnz;
    cfg_known        = 1'b1;
    unique case (cfg_index)
      CFG_ROW_COUNT:   row_count_next   = cfg_data[24:0];
      CFG_BLOCK_COUNT: block_count_next = cfg_data[6:0];
      CFG_TOTAL_NNZ:   total_nnz_next   = cfg_data;
      default:         cfg_known        = 1'b0;
    endcase
    cfg_take        = cfg_write && first_row && cfg_known;
    blocks_eff_next = clamp_blocks(block_count_next);
    // Ceiling division: bias the dividend by divisor minus one.
    div_numer       = {1'b0, total_nnz_next} + {26'd0, blocks_eff_next} - 33'd1;
    rows_eff        = (row_count == '0) ? 25'd1 : row_count;
    blocks_eff      = clamp_blocks(block_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= 25'd1;
      block_count <= 7'd1;
      total_nnz   <= '0;
    end else if (cfg_take) begin
      row_count   <= row_count_next;
      block_count <= block_count_next;
      total_nnz   <= total_nnz_next;
    end
  end

  assign full = q_full || div_busy;
  assign take = push && !full;

  nbrp_target_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_take),
    .numer  (div_numer),
    .denom  (blocks_eff_next),
    .busy   (div_busy),
    .target (target)
  );

  nbrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .row_nnz   (row_nnz),
    .rows      (rows_eff),
    .blocks    (blocks_eff),
    .target    (target),
    .first_row (first_row),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  nbrp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .rd      (q_pop),
    .rd_data (cmd_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  nbrp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (cmd_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .block_index (block_index),
    .range_start (range_start),
    .range_end   (range_end),
    .last        (last)
  );

endmodule

@@ sim/nnz_balanced_row_partitioner_tb.sv @@
// Self-checking testbench for the nonzero-balanced row partitioner.
module nnz_balanced_row_partitioner_tb
  import nbrp_pkg::*;
();

  localparam int unsigned BLOCK_LIMIT = 64;
  localparam longint unsigned ACC_LIMIT = (64'd1 << 33) - 1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 250;

  typedef struct packed {
    logic [5:0]  blk;
    logic [24:0] lo;
    logic [24:0] hi;
    logic        fin;
  } range_t;

  typedef enum int {
    NZ_SMALL,
    NZ_SKEWED,
    NZ_RANDOM,
    NZ_ZERO,
    NZ_FULL
  } nz_shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [23:0] row_nnz = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [5:0]  block_index;
  logic [24:0] range_start;
  logic [24:0] range_end;
  logic        last;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  nnz_balanced_row_partitioner dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .row_nnz(row_nnz),
    .empty(empty),
    .pop(pop),
    .block_index(block_index),
    .range_start(range_start),
    .range_end(range_end),
    .last(last),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the partitioner's registers and range state.
  logic [24:0] cfg_rows = 25'd1;
  logic [6:0]  cfg_blocks = 7'd1;
  logic [31:0] cfg_total = '0;
  logic [31:0] target = 32'd1;
  logic [24:0] row_idx = '0;
  logic [6:0]  cur_blk = '0;
  logic [24:0] open_start = '0;
  logic [32:0] acc_nnz = '0;

  logic [23:0] row_feed[$];
  range_t      range_q[$];
  logic [23:0] batch_rows[$];

  int mismatches = 0;
  int rows_sent = 0;
  int ranges_seen = 0;
  int matrices_done = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_request = 0;
  int hold_served = 0;
  int hold_left = 0;
  int pat_age = 0;
  logic [7:0] stall_pat = 8'hFF;

  function automatic longint unsigned blocks_in_use();
    longint unsigned b;
    b = cfg_blocks;
    if (b == 0) b = 1;
    if (b > BLOCK_LIMIT) b = BLOCK_LIMIT;
    return b;
  endfunction

  task automatic refresh_target();
    longint unsigned b;
    longint unsigned t;
    b = blocks_in_use();
    t = (longint'(cfg_total) + b - 1) / b;
    target = (t == 0) ? 32'd1 : 32'(t);
  endtask

  task automatic mirror_cfg(input logic [1:0] idx, input logic [31:0] data);
    if (row_idx != 0) return;
    case (idx)
      CFG_ROW_COUNT: cfg_rows = data[24:0];
      CFG_BLOCK_COUNT: cfg_blocks = data[6:0];
      CFG_TOTAL_NNZ: cfg_total = data;
      default: return;
    endcase
    refresh_target();
  endtask

  // Works out the range words one accepted row causes.
  task automatic predict_row(input logic [23:0] nnz);
    longint unsigned rows;
    longint unsigned blocks;
    longint unsigned row;
    longint unsigned blk;
    longint unsigned nxt;
    longint unsigned rem_rows;
    longint unsigned rem_blocks;
    longint unsigned b;
    bit split;
    range_t r;
    range_t batch[$];
    rows = (cfg_rows == 0) ? 1 : cfg_rows;
    blocks = blocks_in_use();
    row = row_idx;
    blk = cur_blk;
    nxt = longint'(acc_nnz) + nnz;
    if (nxt > ACC_LIMIT) nxt = ACC_LIMIT;
    rem_rows = (rows > row) ? rows - row : 0;
    rem_blocks = (blocks > blk) ? blocks - blk : 0;
    split = (blk + 1 < blocks) && (acc_nnz != 0) && (nxt > target) &&
            (rem_rows >= rem_blocks);
    if (split) begin
      r = '{blk: 6'(blk), lo: open_start, hi: 25'(row), fin: 1'b0};
      batch = {batch, r};
      blk++;
      cur_blk = 7'(blk);
      open_start = 25'(row);
      acc_nnz = 33'(nnz);
    end else begin
      acc_nnz = 33'(nxt);
    end
    if (row + 1 >= rows) begin
      if (blk < blocks) begin
        r = '{blk: 6'(blk), lo: open_start, hi: 25'(rows), fin: 1'b0};
        batch = {batch, r};
      end
      // Every block left over gets an empty range at the row count.
      for (b = blk + 1; b < blocks && batch.size() < BLOCK_LIMIT; b++) begin
        r = '{blk: 6'(b), lo: 25'(rows), hi: 25'(rows), fin: 1'b0};
        batch = {batch, r};
      end
      row_idx = '0;
      cur_blk = '0;
      open_start = '0;
      acc_nnz = '0;
      refresh_target();
      matrices_done++;
    end else begin
      row_idx = 25'(row + 1);
    end
    if (batch.size() != 0) batch[batch.size() - 1].fin = 1'b1;
    foreach (batch[i]) range_q = {range_q, batch[i]};
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at range word %0d: %s", ranges_seen, msg);
    mismatches++;
  endtask

  task automatic check_range();
    range_t want;
    if (range_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word blk=%0d start=%0d end=%0d last=%0b",
                                block_index, range_start, range_end, last));
    end else begin
      want = range_q.pop_front();
      if (block_index !== want.blk)
        report_mismatch($sformatf("block_index %0d, want %0d", block_index, want.blk));
      if (range_start !== want.lo)
        report_mismatch($sformatf("range_start %0d, want %0d", range_start, want.lo));
      if (range_end !== want.hi)
        report_mismatch($sformatf("range_end %0d, want %0d", range_end, want.hi));
      if (last !== want.fin)
        report_mismatch($sformatf("last %0b, want %0b", last, want.fin));
    end
    ranges_seen++;
  endtask

  // Row sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_row(row_nnz);
        void'(row_feed.pop_front());
        rows_sent++;
      end
      if (!(push && full)) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (row_feed.size() != 0) begin
          push <= 1'b1;
          row_nnz <= row_feed[0];
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Range receiver: rotating stall pattern, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_range();
      if (hold_served != hold_request) begin
        hold_served = hold_request;
        hold_left = HOLD_CYCLES;
      end
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        if (stall_pat == 0) stall_pat = 8'h01;
        pat_age = $urandom_range(16, 96);
      end else begin
        pat_age--;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= stall_pat[0];
      end
      stall_pat = {stall_pat[0], stall_pat[7:1]};
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    mirror_cfg(idx, data);
    cfg_writes++;
    repeat (2) @(negedge clk);
  endtask

  task automatic load_config(input logic [31:0] rows_word, input logic [31:0] blocks_word,
                             input logic [31:0] total_word);
    write_reg(CFG_ROW_COUNT, rows_word);
    write_reg(CFG_BLOCK_COUNT, blocks_word);
    write_reg(CFG_TOTAL_NNZ, total_word);
  endtask

  // Hands the batch to the sender and waits until every range word is back.
  task automatic stream_rows();
    @(negedge clk);
    foreach (batch_rows[i]) row_feed = {row_feed, batch_rows[i]};
    while (row_feed.size() != 0 || range_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [23:0] gen_nnz(input nz_shape_t shape);
    case (shape)
      NZ_SMALL: return 24'($urandom_range(0, 15));
      NZ_SKEWED: return ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                    : 24'($urandom_range(0, 255));
      NZ_RANDOM: return 24'($urandom);
      NZ_ZERO: return '0;
      default: return 24'hFF_FFFF;
    endcase
  endfunction

  initial begin
    int rand_rows;
    int rows;
    int blocks;
    int mats;
    int pick;
    nz_shape_t shape;
    longint unsigned sum;
    logic [31:0] total;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Reset configuration: one row, one block.
    batch_rows = '{24'h00_0000};
    stream_rows();

    // Zero row count and zero block count both act as one.
    load_config(32'd0, 32'd0, 32'd0);
    batch_rows = '{24'hFF_FFFF};
    stream_rows();

    // Block count beyond the limit, maximum total: a full burst of tail ranges.
    load_config(32'd4, 32'd127, 32'hFFFF_FFFF);
    batch_rows = '{24'hFF_FFFF, 24'h00_0000, 24'h00_0001, 24'h80_0000};
    stream_rows();

    // A write to an index outside the register list changes nothing.
    write_reg(CFG_UNUSED, $urandom);

    // Zero total gives a target of one, so a nonzero row splits once the open range holds nonzeros and blocks remain.
    load_config(32'd5, 32'd3, 32'd0);
    batch_rows = '{24'd1, 24'd1, 24'd0, 24'd1, 24'd1};
    stream_rows();

    // A large row count written, then replaced before any row arrives.
    write_reg(CFG_ROW_COUNT, 32'h0100_0000);
    load_config(32'd6, 32'd2, 32'd10);
    batch_rows = '{24'd3, 24'd3, 24'd0, 24'd4, 24'd0, 24'd0};
    stream_rows();

    load_config(32'd3, 32'd1, 32'hFFFF_FFFF);
    batch_rows = '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF};
    stream_rows();

    // Receiver holds off while single-row matrices keep arriving.
    hold_request++;
    load_config(32'd1, 32'd4, $urandom);
    batch_rows = {};
    repeat (24) batch_rows = {batch_rows, gen_nnz(NZ_RANDOM)};
    stream_rows();

    rand_rows = 0;
    while (rand_rows < 105) begin
      pick = $urandom_range(0, 9);
      rows = (pick < 6) ? $urandom_range(1, 12) : (pick < 9) ? $urandom_range(13, 40) : 1;
      pick = $urandom_range(0, 9);
      blocks = (pick < 5) ? $urandom_range(1, 8) : (pick == 5) ? 64 : (pick == 6) ? 0 :
               (pick == 7) ? $urandom_range(65, 127) : $urandom_range(9, 63);
      mats = $urandom_range(1, 3);
      pick = $urandom_range(0, 9);
      shape = (pick < 4) ? NZ_SMALL : (pick < 6) ? NZ_SKEWED : (pick < 8) ? NZ_RANDOM :
              (pick == 8) ? NZ_ZERO : NZ_FULL;
      batch_rows = {};
      sum = 0;
      for (int i = 0; i < rows * mats; i++) begin
        batch_rows = {batch_rows, gen_nnz(shape)};
        if (i < rows) sum += batch_rows[i];
      end
      // Mostly the true total of the matrix; now and then an unrelated one.
      total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
      if ($urandom_range(0, 4) == 0) total = $urandom;
      load_config({7'($urandom), 25'(rows)}, {25'($urandom), 7'(blocks)}, total);
      stream_rows();
      rand_rows += rows * mats;
    end

    $display("Sent %0d rows in %0d matrices over %0d register writes;", rows_sent,
             matrices_done, cfg_writes);
    $display("checked %0d range words with %0d mismatches.", ranges_seen, mismatches);
    if (mismatches == 0)
      $display("nnz_balanced_row_partitioner regression: pass");
    else
      $display("nnz_balanced_row_partitioner regression: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("nnz_balanced_row_partitioner regression: fail");
    $finish;
  end

endmodule
